// ===== design/tlq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlq_pkg
// Shared types, widths and register codes of the thick line quad tessellator.
// ----------------------------------------------------------------------------
package tlq_pkg;

   // Coordinate and field widths.
   localparam int COORD_W  = 32;
   localparam int SCALE_W  = 24;
   localparam int THICK_W  = 31;
   localparam int RATIO_W  = 17;
   localparam int CSR_IDX_W = 3;

   // Fraction bits of coordinates unless a parent overrides them.
   localparam int DEFAULT_FRAC_BITS = 16;

   // Thickness reset is 1311 at 16 fraction bits, rescaled to the format.
   localparam int THICK_BASE      = 1311;
   localparam int THICK_BASE_FRAC = 16;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
   localparam logic [RATIO_W-1:0] RATIO_ONE   = 17'd65536;

   // Shared divider and root unit widths.
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 34;
   localparam int SQRT_IN_W  = 64;
   localparam int SQRT_OUT_W = 32;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THICK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLID    = 3'd4;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SCALE_WB,
      ST_DELTA,
      ST_SQ,
      ST_SQ_WB,
      ST_ROOT_GO,
      ST_ROOT,
      ST_OFF_MUL,
      ST_OFF_WB,
      ST_OFF_DIV,
      ST_RATIO,
      ST_RATIO_DIV,
      ST_EMIT
   } state_type;

   // Saturate a 36 bit signed sum to a 32 bit coordinate.
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [35:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 36'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/tlq_sqrt.sv =====
// ----------------------------------------------------------------------------
// tlq_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tlq_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tlq_pkg::SQRT_IN_W-1:0]    radicand,
   output logic                             done,
   output logic [tlq_pkg::SQRT_OUT_W-1:0]   root
);
   import tlq_pkg::*;

   logic [SQRT_IN_W-1:0] rem_ff, rem_in;
   logic [SQRT_IN_W-1:0] res_ff, res_in;
   logic [SQRT_IN_W-1:0] bit_ff, bit_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SQRT_IN_W-1:0] trial;

   // One digit step: try to subtract the trial value from the remainder.
   always_comb begin
      trial   = res_ff + bit_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(SQRT_IN_W-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[SQRT_OUT_W-1:0];

endmodule

// ===== design/tlq_div.sv =====
// ----------------------------------------------------------------------------
// tlq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlq_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tlq_pkg::DIV_NUM_W-1:0]   dividend,
   input  logic [tlq_pkg::DIV_DEN_W-1:0]   divisor,
   output logic                            done,
   output logic [tlq_pkg::DIV_NUM_W-1:0]   quotient
);
   import tlq_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_sh;

   // Shift one dividend bit into the remainder and subtract where it fits.
   always_comb begin
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], quo_ff[DIV_NUM_W-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/thick_line_quad_tessellator.sv =====
// ----------------------------------------------------------------------------
// thick_line_quad_tessellator
// Turns line segments into thick outline quads (two triangles) with an
// optional fan triangle, and reports the object extent on its last segment.
//
//   Channel  Direction  Handshake               Word
//   req      in         req_valid / req_stall   one segment, two endpoints
//   rsp      out        rsp_valid / rsp_stall   one vertex with extent data
//   csr      in         csr_write_enable        one register write
//
// A segment passes through acceptance, scaling on the shared multiplier, the
// differences, the squares, the square root, the two offset divisions and the
// ratio division, then 6 or 9 vertices, 9 in solid mode. A new segment is
// taken only after the last vertex of the previous one is loaded for output.
// All three divisions run on one 64 step restoring divider. A zero-length
// segment skips the offset divisions, and the ratio division as well when the
// thickness is zero. Reset is synchronous, clears control state and the
// bounding box and loads the configuration reset values. A stalled result
// holds in the output register while the next segment is already taken in.
// ----------------------------------------------------------------------------
module thick_line_quad_tessellator #(
   parameter int COORD_FRAC_BITS = tlq_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [tlq_pkg::COORD_W-1:0]    req_start_x,
   input  logic signed [tlq_pkg::COORD_W-1:0]    req_start_y,
   input  logic signed [tlq_pkg::COORD_W-1:0]    req_end_x,
   input  logic signed [tlq_pkg::COORD_W-1:0]    req_end_y,
   input  logic                                  req_last_segment,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [tlq_pkg::COORD_W-1:0]    rsp_vert_x,
   output logic signed [tlq_pkg::COORD_W-1:0]    rsp_vert_y,
   output logic [tlq_pkg::RATIO_W-1:0]           rsp_length_ratio,
   output logic                                  rsp_vertex_kind,
   output logic [tlq_pkg::COORD_W-1:0]           rsp_extent_width,
   output logic [tlq_pkg::COORD_W-1:0]           rsp_extent_height,
   output logic                                  rsp_extent_valid,
   output logic                                  rsp_last_of_run,
   input  logic                                  csr_write_enable,
   input  logic [tlq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tlq_pkg::COORD_W-1:0]           csr_write_data
);
   import tlq_pkg::*;

   // Thickness reset rescaled to the coordinate format.
   localparam logic [63:0] THICK_RESET_WIDE =
      (64'(THICK_BASE) << COORD_FRAC_BITS) >> THICK_BASE_FRAC;
   localparam logic [THICK_W-1:0] THICK_RESET = THICK_RESET_WIDE[THICK_W-1:0];
   localparam logic [3:0] EMIT_FIRST_QUAD = 4'd3;
   localparam logic [3:0] EMIT_LAST       = 4'd8;

   // Configuration registers.
   logic [SCALE_W-1:0]        scale_ff;
   logic signed [COORD_W-1:0] center_x_ff, center_y_ff;
   logic [THICK_W-1:0]        thick_ff;
   logic                      solid_ff;

   // Sequencer and datapath registers.
   state_type                 state_ff, state_in;
   logic [3:0]                cnt_ff;
   logic signed [COORD_W-1:0] pt_ff  [4];
   logic signed [COORD_W-1:0] crd_ff [4];
   logic                      last_ff;
   logic signed [32:0]        dx_ff, dy_ff;
   logic [31:0]               ax_ff, ay_ff;
   logic [30:0]               axh_ff, ayh_ff;
   logic                      big_ff;
   logic [62:0]               sum_ff;
   logic [32:0]               len_ff;
   logic signed [32:0]        ox_ff, oy_ff;
   logic [RATIO_W-1:0]        ratio_ff;
   logic signed [COORD_W-1:0] box_min_x_ff, box_max_x_ff, box_min_y_ff, box_max_y_ff;
   logic [COORD_W-1:0]        ext_w_ff, ext_h_ff;

   // Output register.
   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] vx_ff, vy_ff;
   logic [RATIO_W-1:0]        rratio_ff;
   logic                      kind_ff, xvalid_ff, lastrun_ff;
   logic [COORD_W-1:0]        xw_ff, xh_ff;

   // Shared multiplier.
   logic signed [32:0]        mul_a, mul_b;
   logic signed [65:0]        mul_p_ff, mul_p_in;

   // Shared units.
   logic                      sqrt_start, sqrt_done;
   logic [SQRT_OUT_W-1:0]     sqrt_root;
   logic                      div_start, div_done;
   logic [DIV_NUM_W-1:0]      div_num, div_quo;
   logic [DIV_DEN_W-1:0]      div_den;

   // Combinational helpers.
   logic                      emit_load;
   logic signed [32:0]        diff;
   logic signed [65:0]        sc_sum;
   logic signed [49:0]        sc_full;
   logic signed [COORD_W-1:0] sc_sat;
   logic signed [32:0]        dx_c, dy_c;
   logic [32:0]               ax_c, ay_c;
   logic                      big_c;
   logic signed [COORD_W-1:0] mnx, mxx, mny, mxy;
   logic [DIV_DEN_W-1:0]      ratio_den;
   logic [3:0]                quad_idx;
   logic                      at_end, side1;
   logic signed [35:0]        bx, by, sox, soy, vx_sum, vy_sum;
   logic signed [COORD_W-1:0] v_x, v_y;
   logic [RATIO_W-1:0]        v_ratio;
   logic                      v_kind, v_last;
   logic [3:0]                emit_first;

   tlq_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({1'b0, sum_ff}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   tlq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Scaling of one endpoint coordinate with rounding to nearest (halves up) and saturation.
   always_comb begin
      diff    = 33'(pt_ff[cnt_ff[1:0]]) -
                33'(cnt_ff[0] ? center_y_ff : center_x_ff);
      sc_sum  = mul_p_ff + 66'sd32768;
      sc_full = sc_sum[65:16];
      if (!sc_full[49] && (sc_full[48:31] != '0)) begin
         sc_sat = 32'sh7FFF_FFFF;
      end else if (sc_full[49] && (sc_full[48:31] != '1)) begin
         sc_sat = 32'sh8000_0000;
      end else begin
         sc_sat = sc_full[COORD_W-1:0];
      end
   end

   // Direction, magnitudes and the new bounding box.
   always_comb begin
      dx_c  = 33'(crd_ff[2]) - 33'(crd_ff[0]);
      dy_c  = 33'(crd_ff[3]) - 33'(crd_ff[1]);
      ax_c  = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
      ay_c  = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
      big_c = ax_c[32] | ax_c[31] | ay_c[32] | ay_c[31];
      mnx = box_min_x_ff;
      mxx = box_max_x_ff;
      mny = box_min_y_ff;
      mxy = box_max_y_ff;
      if (crd_ff[0] < mnx) mnx = crd_ff[0];
      if (crd_ff[2] < mnx) mnx = crd_ff[2];
      if (crd_ff[0] > mxx) mxx = crd_ff[0];
      if (crd_ff[2] > mxx) mxx = crd_ff[2];
      if (crd_ff[1] < mny) mny = crd_ff[1];
      if (crd_ff[3] < mny) mny = crd_ff[3];
      if (crd_ff[1] > mxy) mxy = crd_ff[1];
      if (crd_ff[3] > mxy) mxy = crd_ff[3];
   end

   // Vertex selection for the current emit position.
   always_comb begin
      quad_idx = cnt_ff - EMIT_FIRST_QUAD;
      at_end   = (quad_idx == 4'd1) || (quad_idx == 4'd2) || (quad_idx == 4'd3);
      side1    = (quad_idx == 4'd2) || (quad_idx == 4'd3) || (quad_idx == 4'd4);
      bx       = 36'(at_end ? crd_ff[2] : crd_ff[0]);
      by       = 36'(at_end ? crd_ff[3] : crd_ff[1]);
      sox      = at_end ? 36'(ox_ff) : -36'(ox_ff);
      soy      = at_end ? 36'(oy_ff) : -36'(oy_ff);
      vx_sum   = bx + sox + (side1 ? 36'(oy_ff) : -36'(oy_ff));
      vy_sum   = by + soy + (side1 ? -36'(ox_ff) : 36'(ox_ff));
      if (cnt_ff < EMIT_FIRST_QUAD) begin
         v_kind  = 1'b1;
         v_ratio = '0;
         if (cnt_ff == 4'd0) begin
            v_x = crd_ff[0];
            v_y = crd_ff[1];
         end else if (cnt_ff == 4'd1) begin
            v_x = crd_ff[2];
            v_y = crd_ff[3];
         end else begin
            v_x = '0;
            v_y = '0;
         end
      end else begin
         v_kind  = 1'b0;
         v_ratio = ratio_ff;
         v_x     = sat32(vx_sum);
         v_y     = sat32(vy_sum);
      end
      v_last = (cnt_ff == EMIT_LAST);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_SCALE_WB;
         ST_SCALE_WB:  state_in = (cnt_ff[1:0] == 2'd3) ? ST_DELTA : ST_SCALE;
         ST_DELTA:     state_in = ST_SQ;
         ST_SQ:        state_in = ST_SQ_WB;
         ST_SQ_WB:     state_in = cnt_ff[0] ? ST_ROOT_GO : ST_SQ;
         ST_ROOT_GO:   state_in = ST_ROOT;
         ST_ROOT:      if (sqrt_done) state_in = ST_OFF_MUL;
         ST_OFF_MUL:   state_in = (len_ff == '0) ? ST_RATIO : ST_OFF_WB;
         ST_OFF_WB:    state_in = ST_OFF_DIV;
         ST_OFF_DIV: begin
            if (div_done) state_in = cnt_ff[0] ? ST_RATIO : ST_OFF_MUL;
         end
         ST_RATIO:     state_in = (ratio_den == '0) ? ST_EMIT : ST_RATIO_DIV;
         ST_RATIO_DIV: if (div_done) state_in = ST_EMIT;
         ST_EMIT:      if (emit_load && v_last) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: unit operands and start strobes.
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      mul_a      = '0;
      mul_b      = '0;
      sqrt_start = (state_ff == ST_ROOT_GO);
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      ratio_den  = 34'(len_ff) + 34'(thick_ff);
      emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
      emit_first = solid_ff ? 4'd0 : EMIT_FIRST_QUAD;
      unique case (state_ff)
         ST_SCALE: begin
            mul_a = diff;
            mul_b = 33'(scale_ff);
         end
         ST_SQ: begin
            mul_a = 33'(cnt_ff[0] ? ayh_ff : axh_ff);
            mul_b = 33'(cnt_ff[0] ? ayh_ff : axh_ff);
         end
         ST_OFF_MUL: begin
            mul_a = 33'(cnt_ff[0] ? ay_ff : ax_ff);
            mul_b = 33'(thick_ff);
         end
         ST_OFF_WB: begin
            div_start = 1'b1;
            div_num   = 64'(mul_p_ff[62:0]) + 64'(len_ff);
            div_den   = {len_ff, 1'b0};
         end
         ST_RATIO: begin
            div_start = (ratio_den != '0);
            div_num   = {17'd0, thick_ff, 16'd0} + 64'(ratio_den >> 1);
            div_den   = ratio_den;
         end
         default: begin
         end
      endcase
      mul_p_in = mul_a * mul_b;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= SCALE_RESET;
         center_x_ff <= '0;
         center_y_ff <= '0;
         thick_ff    <= THICK_RESET;
         solid_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCALE:    scale_ff    <= csr_write_data[SCALE_W-1:0];
            CSR_CENTER_X: center_x_ff <= csr_write_data;
            CSR_CENTER_Y: center_y_ff <= csr_write_data;
            CSR_THICK:    thick_ff    <= csr_write_data[THICK_W-1:0];
            CSR_SOLID:    solid_ff    <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         box_min_x_ff <= 32'sh7FFF_FFFF;
         box_max_x_ff <= 32'sh8000_0000;
         box_min_y_ff <= 32'sh7FFF_FFFF;
         box_max_y_ff <= 32'sh8000_0000;
      end else begin
         state_ff <= state_in;
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE:     cnt_ff <= '0;
            ST_SCALE_WB: cnt_ff <= (cnt_ff[1:0] == 2'd3) ? 4'd0 : cnt_ff + 1'b1;
            ST_SQ_WB:    cnt_ff <= cnt_ff[0] ? 4'd0 : cnt_ff + 1'b1;
            ST_OFF_DIV:  if (div_done) cnt_ff <= cnt_ff + 1'b1;
            ST_RATIO:    if (ratio_den == '0) cnt_ff <= emit_first;
            ST_RATIO_DIV: if (div_done) cnt_ff <= emit_first;
            ST_EMIT:     if (emit_load) cnt_ff <= cnt_ff + 1'b1;
            default: begin
            end
         endcase
         // Bounding box update, reported and cleared on the last segment.
         if (state_ff == ST_DELTA) begin
            if (last_ff) begin
               box_min_x_ff <= 32'sh7FFF_FFFF;
               box_max_x_ff <= 32'sh8000_0000;
               box_min_y_ff <= 32'sh7FFF_FFFF;
               box_max_y_ff <= 32'sh8000_0000;
            end else begin
               box_min_x_ff <= mnx;
               box_max_x_ff <= mxx;
               box_min_y_ff <= mny;
               box_max_y_ff <= mxy;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
      unique case (state_ff)
         ST_IDLE: begin
            pt_ff[0] <= req_start_x;
            pt_ff[1] <= req_start_y;
            pt_ff[2] <= req_end_x;
            pt_ff[3] <= req_end_y;
            last_ff  <= req_last_segment;
         end
         ST_SCALE_WB: crd_ff[cnt_ff[1:0]] <= sc_sat;
         ST_DELTA: begin
            dx_ff    <= dx_c;
            dy_ff    <= dy_c;
            ax_ff    <= ax_c[31:0];
            ay_ff    <= ay_c[31:0];
            axh_ff   <= big_c ? ax_c[31:1] : ax_c[30:0];
            ayh_ff   <= big_c ? ay_c[31:1] : ay_c[30:0];
            big_ff   <= big_c;
            ext_w_ff <= mxx - mnx;
            ext_h_ff <= mxy - mny;
         end
         ST_SQ_WB: begin
            if (cnt_ff[0]) begin
               sum_ff <= sum_ff + mul_p_ff[62:0];
            end else begin
               sum_ff <= mul_p_ff[62:0];
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               len_ff <= big_ff ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
            end
         end
         ST_OFF_MUL: begin
            if (len_ff == '0) begin
               ox_ff <= '0;
               oy_ff <= '0;
            end
         end
         ST_OFF_DIV: begin
            if (div_done) begin
               if (cnt_ff[0]) begin
                  oy_ff <= dy_ff[32] ? -33'(div_quo[31:0]) : 33'(div_quo[31:0]);
               end else begin
                  ox_ff <= dx_ff[32] ? -33'(div_quo[31:0]) : 33'(div_quo[31:0]);
               end
            end
         end
         ST_RATIO: if (ratio_den == '0) ratio_ff <= '0;
         ST_RATIO_DIV: begin
            if (div_done) begin
               ratio_ff <= (div_quo > 64'(RATIO_ONE)) ? RATIO_ONE : div_quo[RATIO_W-1:0];
            end
         end
         default: begin
         end
      endcase
      // Output word register.
      if (emit_load) begin
         vx_ff      <= v_x;
         vy_ff      <= v_y;
         rratio_ff  <= v_ratio;
         kind_ff    <= v_kind;
         lastrun_ff <= v_last;
         xvalid_ff  <= v_last && last_ff;
         xw_ff      <= (v_last && last_ff) ? ext_w_ff : '0;
         xh_ff      <= (v_last && last_ff) ? ext_h_ff : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vert_x        = vx_ff;
   assign rsp_vert_y        = vy_ff;
   assign rsp_length_ratio  = rratio_ff;
   assign rsp_vertex_kind   = kind_ff;
   assign rsp_extent_width  = xw_ff;
   assign rsp_extent_height = xh_ff;
   assign rsp_extent_valid  = xvalid_ff;
   assign rsp_last_of_run   = lastrun_ff;

endmodule

// ===== bench/tb_thick_line_quad_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thick_line_quad_tessellator
// Self-checking bench for the thick line quad tessellator. Segments are queued
// by a stimulus process and driven by a clocked driver with random gaps.
// The result side stalls at random. Every accepted segment is run through a
// local fixed point model: scaling, root, offsets, ratio, vertices and
// bounding box. The resulting vertex words are checked in order against the
// block's output. Register settings change between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb_thick_line_quad_tessellator;
   import tlq_pkg::*;

   localparam int WATCHDOG_LIMIT = 8000;
   localparam int RANDOM_PHASES  = 8;
   localparam int ITEMS_PER_PHASE = 56;
   localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] ex;
      logic [31:0] ey;
      logic        last;
   } segment_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [16:0] ratio;
      logic        kind;
      logic [31:0] width;
      logic [31:0] height;
      logic        extent_valid;
      logic        last_of_run;
   } vertex_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_start_x = '0;
   logic [31:0] req_start_y = '0;
   logic [31:0] req_end_x = '0;
   logic [31:0] req_end_y = '0;
   logic req_last_segment = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_vert_x;
   logic signed [31:0] rsp_vert_y;
   logic [16:0] rsp_length_ratio;
   logic rsp_vertex_kind;
   logic [31:0] rsp_extent_width;
   logic [31:0] rsp_extent_height;
   logic rsp_extent_valid;
   logic rsp_last_of_run;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_write_data = '0;

   thick_line_quad_tessellator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_last_segment(req_last_segment),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_vert_x(rsp_vert_x), .rsp_vert_y(rsp_vert_y),
      .rsp_length_ratio(rsp_length_ratio), .rsp_vertex_kind(rsp_vertex_kind),
      .rsp_extent_width(rsp_extent_width), .rsp_extent_height(rsp_extent_height),
      .rsp_extent_valid(rsp_extent_valid), .rsp_last_of_run(rsp_last_of_run),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Queues between stimulus, driver and checker.
   segment_type pending_segments[$];
   vertex_type  expected_vertices[$];
   int mismatch_count = 0;
   bit no_gaps = 1'b0;

   // Model copy of the registers and the bounding box.
   longint unsigned m_scale;
   longint m_center_x;
   longint m_center_y;
   longint unsigned m_thick;
   bit m_solid;
   longint box_min_x, box_max_x, box_min_y, box_max_y;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint scale_point(logic [31:0] p, longint c);
      longint prod;
      prod = (longint'($signed(p)) - c) * longint'(m_scale);
      return clamp32((prod + 64'sd32768) >>> 16);
   endfunction

   // Bitwise integer square root, floor.
   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned rem, res, bitv;
      rem = v;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Half thickness projected on one axis, rounded half away from zero.
   function automatic longint axis_offset(longint d, longint unsigned len);
      longint unsigned mag, q;
      if (len == 0) return 0;
      mag = longint'(d < 0 ? -d : d) * m_thick;
      q = (mag + len) / (2 * len);
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic vertex_type make_vertex(longint x, longint y, logic [16:0] ratio,
                                              logic kind);
      vertex_type v;
      v = '0;
      v.x = 32'(clamp32(x));
      v.y = 32'(clamp32(y));
      v.ratio = ratio;
      v.kind = kind;
      return v;
   endfunction

   function automatic void clear_box();
      box_min_x = 64'sd2147483647;
      box_min_y = 64'sd2147483647;
      box_max_x = -64'sd2147483648;
      box_max_y = -64'sd2147483648;
   endfunction

   // Work out the vertex words that one segment produces.
   function automatic void tessellate(segment_type s);
      longint x0, y0, x1, y1, dx, dy, ox, oy;
      longint unsigned ax, ay, len, den, ratio;
      logic [16:0] r17;
      vertex_type words[$];
      x0 = scale_point(s.sx, m_center_x);
      y0 = scale_point(s.sy, m_center_y);
      x1 = scale_point(s.ex, m_center_x);
      y1 = scale_point(s.ey, m_center_y);
      dx = x1 - x0;
      dy = y1 - y0;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      // Very long segments are halved before the root to keep the squares in range.
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
         ax = ax >> 1;
         ay = ay >> 1;
         len = int_root(ax * ax + ay * ay) * 2;
      end else begin
         len = int_root(ax * ax + ay * ay);
      end
      ox = axis_offset(dx, len);
      oy = axis_offset(dy, len);
      den = len + m_thick;
      ratio = den == 0 ? 0 : ((m_thick << 16) + den / 2) / den;
      if (ratio > 65536) ratio = 65536;
      r17 = 17'(ratio);
      if (m_solid) begin
         words.insert(words.size(), make_vertex(x0, y0, '0, 1'b1));
         words.insert(words.size(), make_vertex(x1, y1, '0, 1'b1));
         words.insert(words.size(), make_vertex(0, 0, '0, 1'b1));
      end
      words.insert(words.size(), make_vertex(x0 - ox - oy, y0 - oy + ox, r17, 1'b0));
      words.insert(words.size(), make_vertex(x1 + ox - oy, y1 + oy + ox, r17, 1'b0));
      words.insert(words.size(), make_vertex(x1 + ox + oy, y1 + oy - ox, r17, 1'b0));
      words.insert(words.size(), make_vertex(x1 + ox + oy, y1 + oy - ox, r17, 1'b0));
      words.insert(words.size(), make_vertex(x0 - ox + oy, y0 - oy - ox, r17, 1'b0));
      words.insert(words.size(), make_vertex(x0 - ox - oy, y0 - oy + ox, r17, 1'b0));
      // The box holds the scaled endpoints, not the extended ones.
      if (x0 < box_min_x) box_min_x = x0;
      if (x1 < box_min_x) box_min_x = x1;
      if (x0 > box_max_x) box_max_x = x0;
      if (x1 > box_max_x) box_max_x = x1;
      if (y0 < box_min_y) box_min_y = y0;
      if (y1 < box_min_y) box_min_y = y1;
      if (y0 > box_max_y) box_max_y = y0;
      if (y1 > box_max_y) box_max_y = y1;
      words[words.size()-1].last_of_run = 1'b1;
      if (s.last) begin
         words[words.size()-1].width = 32'(box_max_x - box_min_x);
         words[words.size()-1].height = 32'(box_max_y - box_min_y);
         words[words.size()-1].extent_valid = 1'b1;
         clear_box();
      end
      foreach (words[i]) expected_vertices.insert(expected_vertices.size(), words[i]);
   endfunction

   // Driver: presents queued segments, with random gaps between words.
   int send_gap = 0;
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) send_gap = pick_gap();
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_segments.size() > 0) begin
            segment_type s;
            s = pending_segments.pop_front();
            req_start_x <= s.sx;
            req_start_y <= s.sy;
            req_end_x <= s.ex;
            req_end_y <= s.ey;
            req_last_segment <= s.last;
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
   end

   // Result side stall, held for random stretches.
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= stall_left > 0;
      end
   end

   // Checker: mirrors register writes, predicts on acceptance, compares results.
   int idle_cycles = 0;
   always @(posedge clock) begin
      vertex_type got, want;
      if (reset) begin
         m_scale = 65536;
         m_center_x = 0;
         m_center_y = 0;
         m_thick = 1311;
         m_solid = 1'b0;
         clear_box();
      end else begin
         idle_cycles++;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SCALE:    m_scale = csr_write_data[SCALE_W-1:0];
               CSR_CENTER_X: m_center_x = longint'($signed(csr_write_data));
               CSR_CENTER_Y: m_center_y = longint'($signed(csr_write_data));
               CSR_THICK:    m_thick = csr_write_data[THICK_W-1:0];
               CSR_SOLID:    m_solid = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            tessellate({req_start_x, req_start_y, req_end_x, req_end_y, req_last_segment});
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            got = {rsp_vert_x, rsp_vert_y, rsp_length_ratio, rsp_vertex_kind,
                   rsp_extent_width, rsp_extent_height, rsp_extent_valid, rsp_last_of_run};
            if (expected_vertices.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected vertex word: x=%h y=%h", rsp_vert_x, rsp_vert_y);
            end else begin
               want = expected_vertices.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Vertex mismatch (x y ratio kind w h ev last)");
                     $display("  expected %h %h %h %b %h %h %b %b", want.x, want.y,
                              want.ratio, want.kind, want.width, want.height,
                              want.extent_valid, want.last_of_run);
                     $display("  actual   %h %h %h %b %h %h %b %b", got.x, got.y,
                              got.ratio, got.kind, got.width, got.height,
                              got.extent_valid, got.last_of_run);
                  end
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Register writes keep the enable high across back to back writes.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                              logic [31:0] ey, logic last);
      pending_segments.insert(pending_segments.size(), {sx, sy, ex, ey, last});
   endtask

   // Wait until every queued segment has gone out and every vertex has come back.
   // Sampled at the falling edge so that all updates of the rising edge are seen.
   task automatic drain();
      while (pending_segments.size() > 0 || req_valid || expected_vertices.size() > 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      int r;
      logic [31:0] base;
      r = $urandom_range(0, 9);
      base = $urandom;
      if (r < 4) return base;
      if (r < 9) return 32'($signed(base[23:0]));
      return r[0] ? COORD_MAX : COORD_MIN;
   endfunction

   function automatic logic [31:0] random_scale();
      case ($urandom_range(0, 5))
         0: return 32'h00FF_FFFF;
         1: return 32'd0;
         2: return $urandom;
         default: return $urandom_range(16384, 131072);
      endcase
   endfunction

   function automatic logic [31:0] random_thickness();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return $urandom;
         default: return $urandom_range(1, 1 << 20);
      endcase
   endfunction

   initial begin
      logic [31:0] sx, sy;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero length, long and extreme segments.
      add_segment(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      add_segment(32'd0, 32'd0, 32'd65536, 32'd0, 1'b0);
      add_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
      add_segment(COORD_MAX, 32'd0, COORD_MIN, 32'd0, 1'b1);
      add_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      add_segment(-32'sd65536, 32'd196608, 32'd327680, -32'sd131072, 1'b1);
      drain();

      // Largest scale and thickness with far centres: saturation and fan words.
      write_reg(CSR_SCALE, 32'hFFFF_FFFF);
      write_reg(CSR_CENTER_X, COORD_MAX);
      write_reg(CSR_CENTER_Y, COORD_MIN);
      write_reg(CSR_THICK, 32'hFFFF_FFFF);
      write_reg(CSR_SOLID, 32'hFFFF_FFFF);
      write_reg(3'd5, $urandom);
      write_reg(3'd7, $urandom);
      end_writes();
      add_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
      add_segment(32'd0, 32'd0, 32'd1, 32'd1, 1'b0);
      add_segment(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
      add_segment(32'd100, 32'd100, 32'd100, 32'd100, 1'b1);
      drain();

      // Scale and thickness zero: every segment collapses, ratio is zero.
      write_reg(CSR_SCALE, 32'd0);
      write_reg(CSR_CENTER_X, 32'd0);
      write_reg(CSR_CENTER_Y, 32'd0);
      write_reg(CSR_THICK, 32'd0);
      write_reg(CSR_SOLID, 32'd0);
      end_writes();
      add_segment(COORD_MAX, COORD_MIN, 32'd5, 32'd7, 1'b0);
      add_segment(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
      drain();

      // Unit scale, zero thickness with real length; then a zero-length fan.
      write_reg(CSR_SCALE, 32'd65536);
      end_writes();
      add_segment(32'd0, 32'd0, 32'd655360, 32'd327680, 1'b0);
      drain();
      write_reg(CSR_SOLID, 32'd1);
      end_writes();
      add_segment(32'd65536, 32'd65536, 32'd65536, 32'd65536, 1'b1);
      drain();

      // Random phases, each with its own settings; some without any idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         no_gaps = (p % 3) == 1;
         write_reg(CSR_SCALE, random_scale());
         write_reg(CSR_CENTER_X, $urandom_range(0, 3) == 0 ? $urandom : 32'd0);
         write_reg(CSR_CENTER_Y, $urandom_range(0, 3) == 0 ? $urandom : 32'd0);
         write_reg(CSR_THICK, random_thickness());
         write_reg(CSR_SOLID, $urandom_range(0, 1));
         end_writes();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            sx = random_coord();
            sy = random_coord();
            // Some segments are degenerate or share an axis.
            case ($urandom_range(0, 9))
               0: add_segment(sx, sy, sx, sy, $urandom_range(0, 5) == 0);
               1: add_segment(sx, sy, random_coord(), sy, $urandom_range(0, 5) == 0);
               default: add_segment(sx, sy, random_coord(), random_coord(),
                                    $urandom_range(0, 5) == 0);
            endcase
         end
         drain();
      end

      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_vertices.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
